// ----- sv/segment_sphere_clearance_check_macros.svh -----
// Assertion macros used by the segment/sphere clearance check checker.
// No dependencies; included by the checker file by its bare name.
`ifndef SEGMENT_SPHERE_CLEARANCE_CHECK_MACROS_SVH
`define SEGMENT_SPHERE_CLEARANCE_CHECK_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SSCC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sscc assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SSCC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sscc assertion failed");

`endif

// ----- sv/sscc_pkg.sv -----
// Shared types and constants of the segment/sphere clearance check.
// No dependencies; used by the front end, the cells and the top level.
`default_nettype none

package sscc_pkg;

	// Number of obstacle cells in the chain (1 to 3).
	localparam int NUM_SPHERES = 3;

	// A segment counts as short when v.v is below this, in units of 2^-24 m^2.
	localparam logic [33:0] SHORT_SQ = 34'd68;

	// Low bit of a register index selects centre or radius; the rest is the sphere.
	localparam logic CFG_SEL_CENTER = 1'b0;
	localparam logic CFG_SEL_RADIUS = 1'b1;

	// One query word; from_x sits in the lowest bits.
	typedef struct packed {
		logic signed [15:0] to_z;
		logic signed [15:0] to_y;
		logic signed [15:0] to_x;
		logic signed [15:0] from_z;
		logic signed [15:0] from_y;
		logic signed [15:0] from_x;
	} query_t;

	// What travels from cell to cell with each segment.
	typedef struct packed {
		logic signed [15:0] from_x;
		logic signed [15:0] from_y;
		logic signed [15:0] from_z;
		logic signed [16:0] vx;
		logic signed [16:0] vy;
		logic signed [16:0] vz;
		logic [33:0]        vv;
		logic               short_seg;
		logic               blocked;
	} seg_t;

	// Configuration write as seen by the cells.
	typedef struct packed {
		logic        valid;
		logic [2:0]  index;
		logic [47:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ----- sv/sscc_front.sv -----
// Front end: direction vector, squared length and short-segment flag.
// Depends on sscc_pkg.
`default_nettype none

module sscc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire sscc_pkg::query_t in_query,
	output logic                 out_valid,
	output sscc_pkg::seg_t       out_seg
);

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [15:0] fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2;
	logic signed [16:0] vx_s1, vy_s1, vz_s1, vx_s2, vy_s2, vz_s2;
	logic [32:0]        sqx_s2, sqy_s2, sqz_s2;
	logic signed [33:0] sqx_w, sqy_w, sqz_w;
	logic [33:0]        vv_w;
	sscc_pkg::seg_t     seg_s3;

	assign sqx_w = vx_s1 * vx_s1;
	assign sqy_w = vy_s1 * vy_s1;
	assign sqz_w = vz_s1 * vz_s1;
	assign vv_w  = 34'(sqx_s2) + 34'(sqy_s2) + 34'(sqz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= in_query.from_x;
			fy_s1 <= in_query.from_y;
			fz_s1 <= in_query.from_z;
			vx_s1 <= $signed({in_query.to_x[15], in_query.to_x})
				- $signed({in_query.from_x[15], in_query.from_x});
			vy_s1 <= $signed({in_query.to_y[15], in_query.to_y})
				- $signed({in_query.from_y[15], in_query.from_y});
			vz_s1 <= $signed({in_query.to_z[15], in_query.to_z})
				- $signed({in_query.from_z[15], in_query.from_z});

			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			fz_s2  <= fz_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			vz_s2  <= vz_s1;
			sqx_s2 <= sqx_w[32:0];
			sqy_s2 <= sqy_w[32:0];
			sqz_s2 <= sqz_w[32:0];

			seg_s3.from_x    <= fx_s2;
			seg_s3.from_y    <= fy_s2;
			seg_s3.from_z    <= fz_s2;
			seg_s3.vx        <= vx_s2;
			seg_s3.vy        <= vy_s2;
			seg_s3.vz        <= vz_s2;
			seg_s3.vv        <= vv_w;
			seg_s3.short_seg <= (vv_w < sscc_pkg::SHORT_SQ);
			seg_s3.blocked   <= 1'b0;
		end
	end

	assign out_valid = vld_s3;
	assign out_seg   = seg_s3;

endmodule

`default_nettype wire

// ----- sv/sscc_cell.sv -----
// One obstacle cell: holds one sphere and tests each passing segment against it.
// Depends on sscc_pkg.
`default_nettype none

module sscc_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [1:0]      slot,
	input  wire sscc_pkg::cfg_wr_t cfg,
	input  wire logic            in_valid,
	input  wire sscc_pkg::seg_t  in_seg,
	output logic                 out_valid,
	output sscc_pkg::seg_t       out_seg
);

	// Four partial products of a 34 x 34 multiply split at bit 32.
	typedef struct packed {
		logic [63:0] p00;
		logic [33:0] p01;
		logic [33:0] p10;
		logic [3:0]  p11;
	} parts_t;

	function automatic parts_t split_mul(input logic [33:0] a, input logic [33:0] b);
		parts_t p;
		p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
		p.p01 = 34'(a[31:0]) * 34'(b[33:32]);
		p.p10 = 34'(b[31:0]) * 34'(a[33:32]);
		p.p11 = 4'(a[33:32]) * 4'(b[33:32]);
		return p;
	endfunction

	function automatic logic [67:0] join_mul(input parts_t p);
		return 68'(p.p00) + (68'(p.p01) << 32) + (68'(p.p10) << 32) + (68'(p.p11) << 64);
	endfunction

	logic [47:0] center_q;
	logic [14:0] radius_q;

	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	sscc_pkg::seg_t             seg_s1, seg_s2, seg_s3, seg_s4, seg_s5, seg_s6, seg_s7;
	logic signed [16:0]         cx_s1, cy_s1, cz_s1;
	logic signed [33:0]         pvx_s2, pvy_s2, pvz_s2;
	logic [32:0]                pcx_s2, pcy_s2, pcz_s2;
	logic [29:0]                rr_s2, rr_s3;
	logic signed [35:0]         cv_s3;
	logic [33:0]                cc_s3;
	logic                       skip_s4, skip_s5, skip_s6;
	parts_t                     lhs_s4, cv2_s4, rrvv_s4;
	logic [67:0]                lhs_s5, cv2_s5, rrvv_s5, lhs_s6;
	logic [68:0]                rhs_s6;

	logic signed [33:0] pvx_w, pvy_w, pvz_w, pcx_w, pcy_w, pcz_w;
	logic               skip_w, hit_w;
	sscc_pkg::seg_t     seg_w;

	// Register writes that land on this cell's sphere.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			radius_q <= '0;
		end else if (cfg.valid && (cfg.index[2:1] == slot)) begin
			if (cfg.index[0] == sscc_pkg::CFG_SEL_CENTER) begin
				center_q <= cfg.data;
			end else begin
				radius_q <= cfg.data[14:0];
			end
		end
	end

	assign pvx_w = cx_s1 * seg_s1.vx;
	assign pvy_w = cy_s1 * seg_s1.vy;
	assign pvz_w = cz_s1 * seg_s1.vz;
	assign pcx_w = cx_s1 * cx_s1;
	assign pcy_w = cy_s1 * cy_s1;
	assign pcz_w = cz_s1 * cz_s1;

	// Spheres whose closest point lies before the start or past the end are skipped.
	assign skip_w = cv_s3[35] || (cv_s3 > $signed({2'b00, seg_s3.vv}));
	assign hit_w  = !skip_s6 && ({1'b0, lhs_s6} <= rhs_s6);

	// The segment word leaves with this sphere's verdict folded into its flag.
	always_comb begin
		seg_w         = seg_s6;
		seg_w.blocked = seg_s6.blocked || hit_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= in_seg;
			cx_s1  <= $signed({center_q[15], center_q[15:0]})
				- $signed({in_seg.from_x[15], in_seg.from_x});
			cy_s1  <= $signed({center_q[31], center_q[31:16]})
				- $signed({in_seg.from_y[15], in_seg.from_y});
			cz_s1  <= $signed({center_q[47], center_q[47:32]})
				- $signed({in_seg.from_z[15], in_seg.from_z});

			seg_s2 <= seg_s1;
			pvx_s2 <= pvx_w;
			pvy_s2 <= pvy_w;
			pvz_s2 <= pvz_w;
			pcx_s2 <= pcx_w[32:0];
			pcy_s2 <= pcy_w[32:0];
			pcz_s2 <= pcz_w[32:0];
			rr_s2  <= 30'(radius_q) * 30'(radius_q);

			seg_s3 <= seg_s2;
			cv_s3  <= 36'(pvx_s2) + 36'(pvy_s2) + 36'(pvz_s2);
			cc_s3  <= 34'(pcx_s2) + 34'(pcy_s2) + 34'(pcz_s2);
			rr_s3  <= rr_s2;

			// When the sphere is not skipped, 0 <= c.v <= v.v so 34 bits hold it.
			seg_s4  <= seg_s3;
			skip_s4 <= skip_w;
			lhs_s4  <= split_mul(cc_s3, seg_s3.vv);
			cv2_s4  <= split_mul(cv_s3[33:0], cv_s3[33:0]);
			rrvv_s4 <= split_mul({4'b0000, rr_s3}, seg_s3.vv);

			seg_s5  <= seg_s4;
			skip_s5 <= skip_s4;
			lhs_s5  <= join_mul(lhs_s4);
			cv2_s5  <= join_mul(cv2_s4);
			rrvv_s5 <= join_mul(rrvv_s4);

			seg_s6  <= seg_s5;
			skip_s6 <= skip_s5;
			lhs_s6  <= lhs_s5;
			rhs_s6  <= 69'(cv2_s5) + 69'(rrvv_s5);

			seg_s7 <= seg_w;
		end
	end

	assign out_valid = vld_s7;
	assign out_seg   = seg_s7;

endmodule

`default_nettype wire

// ----- sv/segment_sphere_clearance_check.sv -----
// Segment/sphere clearance check. Each input word is a segment (from point, to point,
// signed Q3.12 metres); the result word says whether the segment misses every configured
// sphere, or is shorter than 0.002 m. One segment is taken every clock cycle unless the
// pipeline is halted. Each result passes through three front stages, then a chain of one
// cell per sphere, each cell seven stages deep, then the output register. The whole
// pipeline halts while a result waits on m_tready, so s_tready is low exactly when a held
// result is not being taken. Sphere registers are written through the cfg port at any
// time (cfg_ready is always high) and should only change while no segment is in flight.
// Indices 6 and 7 are ignored.
// Depends on sscc_pkg, sscc_front and sscc_cell.
`default_nettype none

module segment_sphere_clearance_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // from_x, from_y, from_z, to_x, to_y, to_z
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // path_free, then zero padding
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);

	logic              adv;
	sscc_pkg::cfg_wr_t cfg;
	logic              chain_valid [sscc_pkg::NUM_SPHERES + 1];
	sscc_pkg::seg_t    chain_seg   [sscc_pkg::NUM_SPHERES + 1];
	logic              out_valid_q;
	logic              path_free_q;

	assign adv       = !out_valid_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sscc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.in_query  (sscc_pkg::query_t'(s_tdata)),
		.out_valid (chain_valid[0]),
		.out_seg   (chain_seg[0])
	);

	for (genvar i = 0; i < sscc_pkg::NUM_SPHERES; i++) begin : g_cell
		sscc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.slot      (2'(i)),
			.cfg       (cfg),
			.in_valid  (chain_valid[i]),
			.in_seg    (chain_seg[i]),
			.out_valid (chain_valid[i + 1]),
			.out_seg   (chain_seg[i + 1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_valid[sscc_pkg::NUM_SPHERES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			path_free_q <= chain_seg[sscc_pkg::NUM_SPHERES].short_seg
				|| !chain_seg[sscc_pkg::NUM_SPHERES].blocked;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, path_free_q};

endmodule

`default_nettype wire

// ----- sv/sscc_checker.sv -----
// Port-level checker for the segment/sphere clearance check, bound to the top level.
// Depends on segment_sphere_clearance_check_macros.svh.
`default_nettype none
`include "segment_sphere_clearance_check_macros.svh"

module sscc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata
);

	// A result word that is not taken stays offered.
	`SSCC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// Only the lowest result bit carries the answer.
	`SSCC_ASSERT_IMP(a_out_pad, clk, arst_n, m_tvalid, m_tdata[7:1] == 7'b0000000)
	// A held result stops the pipeline, so no new segment may enter.
	`SSCC_ASSERT_IMP(a_stall_in, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	// With no result waiting, the block always takes a segment.
	`SSCC_ASSERT_IMP(a_idle_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind segment_sphere_clearance_check sscc_checker u_sscc_checker (.*);

`default_nettype wire
